// File: hdl/tsi_pkg.sv
// Shared types and constants for the timed sample interpolator.
// Holds the segment and wrap codes, the control struct passed between
// pipeline modules, and the configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package tsi_pkg;

  // Which part of the sample history produced a result.
  typedef enum logic [1:0] {
    SEG_HOLD    = 2'd0,
    SEG_OLD_MID = 2'd1,
    SEG_MID_NEW = 2'd2
  } seg_e;

  // Direction taken around the value range in cyclic mode.
  typedef enum logic [1:0] {
    WRAP_NONE = 2'd0,
    WRAP_UP   = 2'd1,
    WRAP_DOWN = 2'd2
  } wrap_e;

  // Per-item control that travels alongside the data through the pipeline.
  typedef struct packed {
    logic  hold;  // query at or before the oldest time
    seg_e  seg;   // segment reported with the result
    wrap_e wrap;  // cyclic correction to apply at the end
    logic  neg;   // sign of the scaled difference
  } ctl_t;

  // Integer bits of the interpolation fraction (saturates at 32767).
  localparam int unsigned FRAC_INT_BITS = 15;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_VALUE   = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE   = 2'd1;
  localparam logic [1:0] REG_CYCLIC_MODE = 2'd2;

endpackage

// File: hdl/tsi_front.sv
// Front end of the interpolator: segment selection, length clamp and
// cyclic direction choice over three register stages.
// Depends on tsi_pkg.
`timescale 1ns / 1ps

module tsi_front #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [VALUE_WIDTH-1:0] oldest_value_i,
  input  logic signed [VALUE_WIDTH-1:0] oldest_time_i,
  input  logic signed [VALUE_WIDTH-1:0] middle_value_i,
  input  logic signed [VALUE_WIDTH-1:0] middle_time_i,
  input  logic signed [VALUE_WIDTH-1:0] newest_value_i,
  input  logic signed [VALUE_WIDTH-1:0] newest_time_i,
  input  logic signed [VALUE_WIDTH-1:0] query_time_i,
  input  logic                          cyclic_mode_i,
  input  logic signed [VALUE_WIDTH:0]   range_i,
  output logic                          vld_o,
  output tsi_pkg::ctl_t                 ctl_o,
  output logic signed [VALUE_WIDTH-1:0] a_o,
  output logic [VALUE_WIDTH-1:0]        xmag_o,
  output logic [VALUE_WIDTH-1:0]        un_o,
  output logic [FRACTION_BITS:0]        ud_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned CW = ((VALUE_WIDTH > FRACTION_BITS) ? VALUE_WIDTH : FRACTION_BITS) + 1;

  localparam logic [F:0] FIX_ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] LEN_HALF = {2'b01, {(F-1){1'b0}}};
  localparam logic [F:0] LEN_MIN  = (F+1)'(((1 << F) + 30) / 60);

  // Sign-extended copies of the input fields.
  logic signed [W:0] q_x, t2_x, t1_x, t0_x, v2_x, v1_x, v0_x;
  assign q_x  = {query_time_i[W-1], query_time_i};
  assign t2_x = {oldest_time_i[W-1], oldest_time_i};
  assign t1_x = {middle_time_i[W-1], middle_time_i};
  assign t0_x = {newest_time_i[W-1], newest_time_i};
  assign v2_x = {oldest_value_i[W-1], oldest_value_i};
  assign v1_x = {middle_value_i[W-1], middle_value_i};
  assign v0_x = {newest_value_i[W-1], newest_value_i};

  // Stage 1: compare the query against both sample times and pick a segment.
  logic                 hold_c, first_c;
  logic signed [W:0]    num_c, dlen_c, dval_c;
  logic signed [W-1:0]  a_c;
  tsi_pkg::seg_e        seg_c;

  assign hold_c = query_time_i <= oldest_time_i;
  assign first_c = query_time_i <= middle_time_i;

  always_comb begin
    if (first_c) begin
      num_c  = q_x - t2_x;
      dlen_c = t1_x - t2_x;
      dval_c = v1_x - v2_x;
    end else begin
      num_c  = q_x - t1_x;
      dlen_c = t0_x - t1_x;
      dval_c = v0_x - v1_x;
    end
    a_c = (hold_c || first_c) ? oldest_value_i : middle_value_i;
    if (hold_c) begin
      seg_c = tsi_pkg::SEG_HOLD;
    end else if (first_c) begin
      seg_c = tsi_pkg::SEG_OLD_MID;
    end else begin
      seg_c = tsi_pkg::SEG_MID_NEW;
    end
  end

  logic                s1_vld_q;
  logic                s1_hold_q;
  tsi_pkg::seg_e       s1_seg_q;
  logic signed [W-1:0] s1_a_q;
  logic signed [W:0]   s1_xd_q;
  logic [W-1:0]        s1_un_q;
  logic signed [W:0]   s1_d_q;

  // Stage 2: clamp the segment length and form both wrapped differences.
  logic [W:0]          dmag_c;
  logic [CW-1:0]       dm_x;
  logic [F:0]          ud_c;
  logic signed [W+1:0] xd_w, r_w, xu_c, xn_c;

  assign dmag_c = s1_d_q[W] ? -s1_d_q : s1_d_q;
  assign dm_x   = CW'(dmag_c);

  always_comb begin
    if (dm_x < CW'(LEN_MIN)) begin
      ud_c = LEN_MIN;
    end else if (dm_x > CW'(LEN_HALF)) begin
      ud_c = FIX_ONE;
    end else begin
      ud_c = dm_x[F:0];
    end
  end

  assign xd_w = {s1_xd_q[W], s1_xd_q};
  assign r_w  = {range_i[W], range_i};
  assign xu_c = xd_w + r_w;
  assign xn_c = xd_w - r_w;

  logic                s2_vld_q;
  logic                s2_hold_q;
  tsi_pkg::seg_e       s2_seg_q;
  logic signed [W-1:0] s2_a_q;
  logic signed [W:0]   s2_xd_q;
  logic signed [W+1:0] s2_xu_q, s2_xn_q;
  logic [W-1:0]        s2_un_q;
  logic [F:0]          s2_ud_q;
  logic                s2_lneg_q;

  // Stage 3: take the shortest way around the range in cyclic mode.
  logic [W+1:0]   md_c, mu_c, mn_c;
  logic [W+1:0]   xmag_c;
  logic           xneg_c;
  tsi_pkg::ctl_t  ctl_c;

  assign md_c = (W+2)'(s2_xd_q[W] ? -s2_xd_q : s2_xd_q);
  assign mu_c = s2_xu_q[W+1] ? -s2_xu_q : s2_xu_q;
  assign mn_c = s2_xn_q[W+1] ? -s2_xn_q : s2_xn_q;

  always_comb begin
    ctl_c.hold = s2_hold_q;
    ctl_c.seg  = s2_seg_q;
    if (cyclic_mode_i && (mu_c < md_c)) begin
      ctl_c.wrap = tsi_pkg::WRAP_UP;
      xmag_c     = mu_c;
      xneg_c     = s2_xu_q[W+1];
    end else if (cyclic_mode_i && (mn_c < md_c)) begin
      ctl_c.wrap = tsi_pkg::WRAP_DOWN;
      xmag_c     = mn_c;
      xneg_c     = s2_xn_q[W+1];
    end else begin
      ctl_c.wrap = tsi_pkg::WRAP_NONE;
      xmag_c     = md_c;
      xneg_c     = s2_xd_q[W];
    end
    ctl_c.neg = xneg_c ^ s2_lneg_q;
  end

  // Valid bits for the three stages.
  logic s3_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hold_q <= hold_c;
      s1_seg_q  <= seg_c;
      s1_a_q    <= a_c;
      s1_xd_q   <= dval_c;
      s1_un_q   <= num_c[W-1:0];
      s1_d_q    <= dlen_c;

      s2_hold_q <= s1_hold_q;
      s2_seg_q  <= s1_seg_q;
      s2_a_q    <= s1_a_q;
      s2_xd_q   <= s1_xd_q;
      s2_xu_q   <= xu_c;
      s2_xn_q   <= xn_c;
      s2_un_q   <= s1_un_q;
      s2_ud_q   <= ud_c;
      s2_lneg_q <= s1_d_q[W];

      ctl_o  <= ctl_c;
      a_o    <= s2_a_q;
      xmag_o <= xmag_c[W-1:0];
      un_o   <= s2_un_q;
      ud_o   <= s2_ud_q;
    end
  end

  assign vld_o = s3_vld_q;

endmodule

// File: hdl/tsi_div.sv
// Pipelined restoring divider for the interpolation fraction: one quotient
// bit per stage, with a saturation check in front. Carries side data along.
// Depends on tsi_pkg.
`timescale 1ns / 1ps

module tsi_div #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned SIDE_W        = 64
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         vld_i,
  input  tsi_pkg::ctl_t                                ctl_i,
  input  logic [SIDE_W-1:0]                            side_i,
  input  logic [VALUE_WIDTH-1:0]                       un_i,
  input  logic [FRACTION_BITS:0]                       ud_i,
  output logic                                         vld_o,
  output tsi_pkg::ctl_t                                ctl_o,
  output logic [SIDE_W-1:0]                            side_o,
  output logic [tsi_pkg::FRAC_INT_BITS+FRACTION_BITS-1:0] quo_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned I  = tsi_pkg::FRAC_INT_BITS;
  localparam int unsigned K  = I + F;
  localparam int unsigned UW = W + F + 1;

  localparam logic [K-1:0] FRAC_LIMIT = {{I{1'b1}}, {F{1'b0}}};

  // Stage 0 holds the operands; stage i holds i quotient bits.
  logic [K:0]          vld_q;
  tsi_pkg::ctl_t       ctl_q  [K+1];
  logic [SIDE_W-1:0]   side_q [K+1];
  logic [K:0]          sat_q;
  logic [F:0]          ud_q   [K+1];
  logic [F:0]          rem_q  [K+1];
  logic [K-1:0]        dvd_q  [K+1];
  logic [K-1:0]        quo_q  [K+1];

  logic [F:0]          rem_d  [K+1];
  logic [K-1:0]        dvd_d  [K+1];
  logic [K-1:0]        quo_d  [K+1];
  logic                sat_c;
  logic [UW-1:0]       un_x;

  // Quotient of 32768 or more saturates; otherwise the top of the
  // dividend is already below the divisor.
  assign un_x  = UW'(un_i);
  assign sat_c = un_x >= UW'({ud_i, {I{1'b0}}});

  // One restoring step per stage.
  always_comb begin
    logic [F+1:0] trial;
    logic         ge;
    rem_d[0] = un_x[F+I:I];
    dvd_d[0] = {un_i[I-1:0], {F{1'b0}}};
    quo_d[0] = '0;
    for (int i = 1; i <= K; i++) begin
      trial    = {rem_q[i-1], dvd_q[i-1][K-1]};
      ge       = trial >= {1'b0, ud_q[i-1]};
      rem_d[i] = ge ? (F+1)'(trial - {1'b0, ud_q[i-1]}) : trial[F:0];
      dvd_d[i] = {dvd_q[i-1][K-2:0], 1'b0};
      quo_d[i] = {quo_q[i-1][K-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[K-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0]  <= ctl_i;
      side_q[0] <= side_i;
      sat_q[0]  <= sat_c;
      ud_q[0]   <= ud_i;
      for (int i = 0; i <= K; i++) begin
        rem_q[i] <= rem_d[i];
        dvd_q[i] <= dvd_d[i];
        quo_q[i] <= quo_d[i];
      end
      for (int i = 1; i <= K; i++) begin
        ctl_q[i]  <= ctl_q[i-1];
        side_q[i] <= side_q[i-1];
        sat_q[i]  <= sat_q[i-1];
        ud_q[i]   <= ud_q[i-1];
      end
    end
  end

  // Cap the fraction at 32767 whole units.
  logic over_c;
  assign over_c = (&quo_q[K][K-1:F]) && (|quo_q[K][F-1:0]);
  assign quo_o  = (sat_q[K] || over_c) ? FRAC_LIMIT : quo_q[K];
  assign vld_o  = vld_q[K];
  assign ctl_o  = ctl_q[K];
  assign side_o = side_q[K];

endmodule

// File: hdl/tsi_mul.sv
// Scales the value difference by the fraction: two partial products in the
// first stage, their sum truncated to whole fraction bits in the second.
// Depends on tsi_pkg.
`timescale 1ns / 1ps

module tsi_mul #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            vld_i,
  input  tsi_pkg::ctl_t                                   ctl_i,
  input  logic signed [VALUE_WIDTH-1:0]                   a_i,
  input  logic [VALUE_WIDTH-1:0]                          xmag_i,
  input  logic [tsi_pkg::FRAC_INT_BITS+FRACTION_BITS-1:0] quo_i,
  output logic                                            vld_o,
  output tsi_pkg::ctl_t                                   ctl_o,
  output logic signed [VALUE_WIDTH-1:0]                   a_o,
  output logic [VALUE_WIDTH+tsi_pkg::FRAC_INT_BITS-1:0]   pm_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned K  = tsi_pkg::FRAC_INT_BITS + F;
  localparam int unsigned XL = W / 2;
  localparam int unsigned XH = W - XL;

  // Stage 1: split the difference magnitude into two halves.
  logic [XL+K-1:0] pp_lo_c, pp_lo_q;
  logic [XH+K-1:0] pp_hi_c, pp_hi_q;
  assign pp_lo_c = {{K{1'b0}}, xmag_i[XL-1:0]} * {{XL{1'b0}}, quo_i};
  assign pp_hi_c = {{K{1'b0}}, xmag_i[W-1:XL]} * {{XH{1'b0}}, quo_i};

  logic                m1_vld_q;
  tsi_pkg::ctl_t       m1_ctl_q;
  logic signed [W-1:0] m1_a_q;

  // Stage 2: combine and drop the fraction bits (truncation toward zero).
  logic [W+K-1:0] full_c;
  assign full_c = {pp_hi_q, {XL{1'b0}}} + (W+K)'(pp_lo_q);

  logic m2_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (en_i) begin
      m1_vld_q <= vld_i;
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q  <= pp_lo_c;
      pp_hi_q  <= pp_hi_c;
      m1_ctl_q <= ctl_i;
      m1_a_q   <= a_i;
      ctl_o    <= m1_ctl_q;
      a_o      <= m1_a_q;
      pm_o     <= full_c[W+K-1:F];
    end
  end

  assign vld_o = m2_vld_q;

endmodule

// File: hdl/timed_sample_interpolator.sv
// Timed sample interpolator: linear interpolation over three timed samples.
// One transfer per cycle is taken and returned while the result stream is not
// stalled, the fraction divider giving one quotient bit per pipeline stage.
// Reset clears all valid bits and loads min_value with the most positive value,
// max_value with the most negative value, cyclic mode off.
`timescale 1ns / 1ps

module timed_sample_interpolator #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned PDATA_W = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int unsigned PADDR_W = (VALUE_WIDTH > 32) ? 5 : 4,
  localparam int unsigned TIN_W   = ((7 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned TOUT_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream; tdata from bit 0 up: oldest_value, oldest_time,
  // middle_value, middle_time, newest_value, newest_time, query_time.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TIN_W-1:0]   s_axis_tdata,
  // Result stream; tdata: result_value. tuser: segment_used.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TOUT_W-1:0]  m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned K  = tsi_pkg::FRAC_INT_BITS + F;
  localparam int unsigned PW = W + tsi_pkg::FRAC_INT_BITS;
  localparam int unsigned OW = W + 17;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W:0]   RANGE_RST = {1'b1, {(W-1){1'b0}}, 1'b1};

  // Configuration registers and values derived from them.
  logic signed [W-1:0] min_value_q, max_value_q;
  logic                cyclic_mode_q;
  logic signed [W:0]   range_q;
  logic                rng_ok_q;
  logic [1:0]          reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1 -: 2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q   <= VMAX;
      max_value_q   <= VMIN;
      cyclic_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tsi_pkg::REG_MIN_VALUE:   min_value_q   <= $signed(pwdata[W-1:0]);
        tsi_pkg::REG_MAX_VALUE:   max_value_q   <= $signed(pwdata[W-1:0]);
        tsi_pkg::REG_CYCLIC_MODE: cyclic_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q  <= RANGE_RST;
      rng_ok_q <= 1'b0;
    end else begin
      range_q  <= {max_value_q[W-1], max_value_q} - {min_value_q[W-1], min_value_q};
      rng_ok_q <= min_value_q < max_value_q;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      tsi_pkg::REG_MIN_VALUE:   prdata = PDATA_W'(min_value_q);
      tsi_pkg::REG_MAX_VALUE:   prdata = PDATA_W'(max_value_q);
      tsi_pkg::REG_CYCLIC_MODE: prdata = PDATA_W'(cyclic_mode_q);
      default:                  prdata = '0;
    endcase
  end

  // The whole pipeline advances whenever the output register can move.
  logic out_vld_q;
  logic en;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Front end.
  logic                fr_vld;
  tsi_pkg::ctl_t       fr_ctl;
  logic signed [W-1:0] fr_a;
  logic [W-1:0]        fr_xmag, fr_un;
  logic [F:0]          fr_ud;

  tsi_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .vld_i          (s_axis_tvalid),
    .oldest_value_i (s_axis_tdata[0*W +: W]),
    .oldest_time_i  (s_axis_tdata[1*W +: W]),
    .middle_value_i (s_axis_tdata[2*W +: W]),
    .middle_time_i  (s_axis_tdata[3*W +: W]),
    .newest_value_i (s_axis_tdata[4*W +: W]),
    .newest_time_i  (s_axis_tdata[5*W +: W]),
    .query_time_i   (s_axis_tdata[6*W +: W]),
    .cyclic_mode_i  (cyclic_mode_q),
    .range_i        (range_q),
    .vld_o          (fr_vld),
    .ctl_o          (fr_ctl),
    .a_o            (fr_a),
    .xmag_o         (fr_xmag),
    .un_o           (fr_un),
    .ud_o           (fr_ud)
  );

  // Fraction divider; the start value and difference ride alongside.
  logic            dv_vld;
  tsi_pkg::ctl_t   dv_ctl;
  logic [2*W-1:0]  dv_side;
  logic [K-1:0]    dv_quo;

  tsi_div #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .SIDE_W        (2 * VALUE_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .ctl_i  (fr_ctl),
    .side_i ({fr_a, fr_xmag}),
    .un_i   (fr_un),
    .ud_i   (fr_ud),
    .vld_o  (dv_vld),
    .ctl_o  (dv_ctl),
    .side_o (dv_side),
    .quo_o  (dv_quo)
  );

  // Scaling of the difference.
  logic                ml_vld;
  tsi_pkg::ctl_t       ml_ctl;
  logic signed [W-1:0] ml_a;
  logic [PW-1:0]       ml_pm;

  tsi_mul #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .ctl_i  (dv_ctl),
    .a_i    ($signed(dv_side[2*W-1:W])),
    .xmag_i (dv_side[W-1:0]),
    .quo_i  (dv_quo),
    .vld_o  (ml_vld),
    .ctl_o  (ml_ctl),
    .a_o    (ml_a),
    .pm_o   (ml_pm)
  );

  // Add stage: the sum plus both wrap-corrected variants.
  logic signed [OW-1:0] a_x, r_x, pm_s, o_c, osub_c, oadd_c;
  assign a_x    = OW'(ml_a);
  assign r_x    = OW'(range_q);
  assign pm_s   = ml_ctl.neg ? -$signed(OW'(ml_pm)) : $signed(OW'(ml_pm));
  assign o_c    = a_x + pm_s;
  assign osub_c = a_x + pm_s - r_x;
  assign oadd_c = a_x + pm_s + r_x;

  logic                 a1_vld_q;
  tsi_pkg::ctl_t        a1_ctl_q;
  logic signed [W-1:0]  a1_a_q;
  logic signed [OW-1:0] a1_o_q, a1_osub_q, a1_oadd_q;

  // Output stage: wrap correction, range clamp, final saturation and the held value.
  logic signed [OW-1:0] min_x, max_x, o_sel;
  logic signed [W-1:0]  res_c;
  tsi_pkg::seg_e        seg_c;

  assign min_x = OW'(min_value_q);
  assign max_x = OW'(max_value_q);

  always_comb begin
    o_sel = a1_o_q;
    if ((a1_ctl_q.wrap == tsi_pkg::WRAP_UP) && (a1_o_q > max_x)) begin
      o_sel = a1_osub_q;
    end else if ((a1_ctl_q.wrap == tsi_pkg::WRAP_DOWN) && (a1_o_q < min_x)) begin
      o_sel = a1_oadd_q;
    end
    if (rng_ok_q) begin
      if (o_sel < min_x) begin
        o_sel = min_x;
      end
      if (o_sel > max_x) begin
        o_sel = max_x;
      end
    end
    if (o_sel > OW'(VMAX)) begin
      res_c = VMAX;
    end else if (o_sel < OW'(VMIN)) begin
      res_c = VMIN;
    end else begin
      res_c = o_sel[W-1:0];
    end
    seg_c = a1_ctl_q.seg;
    if (a1_ctl_q.hold) begin
      res_c = a1_a_q;
      seg_c = tsi_pkg::SEG_HOLD;
    end
  end

  logic signed [W-1:0] out_value_q;
  tsi_pkg::seg_e       out_seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a1_vld_q  <= ml_vld;
      out_vld_q <= a1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_ctl_q    <= ml_ctl;
      a1_a_q      <= ml_a;
      a1_o_q      <= o_c;
      a1_osub_q   <= osub_c;
      a1_oadd_q   <= oadd_c;
      out_value_q <= res_c;
      out_seg_q   <= seg_c;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TOUT_W'($unsigned(out_value_q));
  assign m_axis_tuser  = out_seg_q;

endmodule

// File: tb/timed_sample_interpolator_tb.sv
// Self-checking testbench for the timed sample interpolator.
// Sends sample histories over the input stream, predicts every result in-line and
// checks the output stream transfer by transfer; depends on tsi_pkg and the RTL top.
`timescale 1ns / 1ps

module timed_sample_interpolator_tb;

  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int LATENCY = FRAC_W + 23;

  // Value range and fixed-point constants used by the predictor.
  localparam longint VMAX       = 64'sd2147483647;
  localparam longint VMIN       = -64'sd2147483648;
  localparam longint FIX_ONE    = 64'sd1 << FRAC_W;
  localparam longint SPAN_MIN   = (FIX_ONE + 30) / 60;
  localparam longint SPAN_HALF  = FIX_ONE / 2;
  localparam longint FRAC_LIMIT = 64'sd32767 << FRAC_W;
  localparam longint WIDE_LIMIT = 64'sd1 << 60;

  // Register index that the block does not implement.
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int HOLDOFF_CYCLES = 200;
  localparam int CYCLE_LIMIT    = 100000;
  localparam int PRINT_LIMIT    = 40;

  // One input transfer; oldest_value sits in the lowest bits of tdata.
  typedef struct packed {
    logic signed [VALUE_W-1:0] query_time;
    logic signed [VALUE_W-1:0] newest_time;
    logic signed [VALUE_W-1:0] newest_value;
    logic signed [VALUE_W-1:0] middle_time;
    logic signed [VALUE_W-1:0] middle_value;
    logic signed [VALUE_W-1:0] oldest_time;
    logic signed [VALUE_W-1:0] oldest_value;
  } sample_set_t;

  typedef struct packed {
    tsi_pkg::seg_e      seg;
    logic [VALUE_W-1:0] value;
  } interp_result_t;

  logic clk_i;
  logic rst_ni;

  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7*VALUE_W-1:0] s_axis_tdata;   // oldest_value .. query_time, low bits first
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [VALUE_W-1:0]   m_axis_tdata;   // result_value
  logic [1:0]           m_axis_tuser;   // segment_used

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Configuration as the predictor sees it.
  longint cfg_min;
  longint cfg_max;
  bit     cfg_cyclic;

  interp_result_t pending_results[$];

  bit          src_gaps_on;
  bit          sink_gaps_on;
  int          holdoff_requests = 0;
  int          holdoffs_served  = 0;
  int          mismatch_count   = 0;
  int          sets_sent        = 0;
  int          results_checked  = 0;
  int          settings_applied = 0;
  int unsigned cycle_count      = 0;

  timed_sample_interpolator #(
    .VALUE_WIDTH  (VALUE_W),
    .FRACTION_BITS(FRAC_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: cycle limit of %0d reached", CYCLE_LIMIT);
      $display("timed_sample_interpolator: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // a + (b - a) * t, the product truncated toward zero and limited in size.
  function automatic longint blend(input longint a, input longint b, input longint t);
    longint              x;
    logic [127:0]        prod;
    longint unsigned     m;
    x    = b - a;
    prod = {64'd0, magnitude(x)} * {64'd0, magnitude(t)};
    if (prod[127:64+FRAC_W] != 0) m = WIDE_LIMIT;
    else m = prod[64+FRAC_W-1:FRAC_W];
    if (m > WIDE_LIMIT) m = WIDE_LIMIT;
    return ((x < 0) != (t < 0)) ? a - longint'(m) : a + longint'(m);
  endfunction

  function automatic interp_result_t interpolate_expected(input sample_set_t s);
    interp_result_t  r;
    longint          v_old, t_old, v_mid, t_mid, v_new, t_new, q;
    longint          a, b, start, span, frac, o, rng, up, dn;
    longint unsigned un, ud, quo, rem, m, direct;
    v_old = $signed(s.oldest_value);
    t_old = $signed(s.oldest_time);
    v_mid = $signed(s.middle_value);
    t_mid = $signed(s.middle_time);
    v_new = $signed(s.newest_value);
    t_new = $signed(s.newest_time);
    q     = $signed(s.query_time);
    r.seg   = tsi_pkg::SEG_HOLD;
    r.value = s.oldest_value;
    // A query at or before the oldest time holds the oldest value, unclamped.
    if (q <= t_old) return r;
    if (q <= t_mid) begin
      a = v_old; b = v_mid; start = t_old; span = t_mid - t_old;
      r.seg = tsi_pkg::SEG_OLD_MID;
    end else begin
      a = v_mid; b = v_new; start = t_mid; span = t_new - t_mid;
      r.seg = tsi_pkg::SEG_MID_NEW;
    end
    // Segment length keeps its sign; zero counts as positive.
    if (magnitude(span) < SPAN_MIN) span = (span < 0) ? -SPAN_MIN : SPAN_MIN;
    else if (magnitude(span) > SPAN_HALF) span = (span < 0) ? -FIX_ONE : FIX_ONE;
    // Fraction truncated toward zero and saturated.
    un  = magnitude(q - start);
    ud  = magnitude(span);
    quo = un / ud;
    rem = un % ud;
    if (quo >= 32767) m = FRAC_LIMIT;
    else m = (quo << FRAC_W) + ((rem << FRAC_W) / ud);
    if (m > FRAC_LIMIT) m = FRAC_LIMIT;
    frac = (((q - start) < 0) != (span < 0)) ? -longint'(m) : longint'(m);
    // Cyclic mode goes the shorter way around the range.
    if (cfg_cyclic) begin
      rng    = cfg_max - cfg_min;
      up     = b + rng;
      dn     = b - rng;
      direct = magnitude(b - a);
      if (magnitude(up - a) < direct) begin
        o = blend(a, up, frac);
        if (o > cfg_max) o -= rng;
      end else if (magnitude(dn - a) < direct) begin
        o = blend(a, dn, frac);
        if (o < cfg_min) o += rng;
      end else begin
        o = blend(a, b, frac);
      end
    end else begin
      o = blend(a, b, frac);
    end
    if (cfg_min < cfg_max) begin
      if (o < cfg_min) o = cfg_min;
      if (o > cfg_max) o = cfg_max;
    end
    if (o > VMAX) o = VMAX;
    if (o < VMIN) o = VMIN;
    r.value = VALUE_W'(o);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sample_set_t make_set(input longint ov, input longint ot,
                                           input longint mv, input longint mt,
                                           input longint nv, input longint nt,
                                           input longint q);
    sample_set_t s;
    s.oldest_value = VALUE_W'(ov);
    s.oldest_time  = VALUE_W'(ot);
    s.middle_value = VALUE_W'(mv);
    s.middle_time  = VALUE_W'(mt);
    s.newest_value = VALUE_W'(nv);
    s.newest_time  = VALUE_W'(nt);
    s.query_time   = VALUE_W'(q);
    return s;
  endfunction

  function automatic longint rand_word();
    int w;
    w = $urandom;
    return w;
  endfunction

  // Segment lengths spread over the short, normal and long clamp regions.
  function automatic longint pick_span();
    longint d;
    case ($urandom_range(0, 3))
      0: d = $urandom_range(0, 1200);
      1: d = $urandom_range(1000, 34000);
      2: d = $urandom_range(30000, 300000);
      default: d = $urandom_range(0, 65536);
    endcase
    if ($urandom_range(0, 9) == 0) d = -d;
    return d;
  endfunction

  function automatic longint pick_value();
    longint v;
    case ($urandom_range(0, 3))
      0: v = rand_word();
      1: v = longint'($urandom_range(0, 1310720)) - 655360;
      default: begin
        if (cfg_min < cfg_max) v = cfg_min + $urandom_range(0, 32'(cfg_max - cfg_min));
        else v = longint'($urandom_range(0, 1310720)) - 655360;
      end
    endcase
    return v;
  endfunction

  // Mostly ordered histories with the query placed around the segments;
  // one in ten is pure noise.
  function automatic sample_set_t random_sample_set();
    sample_set_t s;
    longint      t0, t1, t2, d1, d2, q;
    if ($urandom_range(0, 9) == 0) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return s;
    end
    t0 = rand_word() >>> 2;
    d1 = pick_span();
    d2 = pick_span();
    t1 = t0 + d1;
    t2 = t1 + d2;
    case ($urandom_range(0, 6))
      0: q = t0 - $urandom_range(0, 2000);
      1, 2: q = t0 + $urandom_range(1, 32'(magnitude(d1) + 16));
      3: q = t1 + $urandom_range(1, 32'(magnitude(d2) + 16));
      4: q = t2 + $urandom_range(0, 4 * FIX_ONE);
      5: q = t1 + $urandom_range(0, 1);
      default: q = rand_word();
    endcase
    return make_set(pick_value(), t0, pick_value(), t1, pick_value(), t2, q);
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("ERROR at %0t: %s, got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one sample set and record its expected result once the transfer happens.
  task automatic send_sample_set(input sample_set_t s);
    if (src_gaps_on && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(interpolate_expected(s));
    sets_sent++;
  endtask

  task automatic send_random_sets(input int count);
    repeat (count) send_sample_set(random_sample_set());
  endtask

  // Stop offering and wait until every expected result has been transferred.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input longint lo, input longint hi, input bit wrap);
    wait_for_results();
    write_register(tsi_pkg::REG_MIN_VALUE, 32'(lo));
    write_register(tsi_pkg::REG_MAX_VALUE, 32'(hi));
    write_register(tsi_pkg::REG_CYCLIC_MODE, {31'd0, wrap});
    cfg_min    = lo;
    cfg_max    = hi;
    cfg_cyclic = wrap;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver: random idling, plus long hold-offs counted here on request.
  initial begin : result_sink
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (holdoffs_served != holdoff_requests) begin
        holdoffs_served++;
        stall_left    = HOLDOFF_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_gaps_on && $urandom_range(0, 99) < 11);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk_i) begin : result_checker
    interp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no sample set pending", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value)
          report_mismatch("result_value", m_axis_tdata, want.value);
        if (m_axis_tuser !== want.seg)
          report_mismatch("segment_used", VALUE_W'(m_axis_tuser), VALUE_W'(want.seg));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Held oldest value and the choice between the two segments.
  task automatic test_hold_and_segments();
    send_sample_set(make_set(VMAX, 0, 1, FIX_ONE / 4, 2, FIX_ONE / 2, 0));
    send_sample_set(make_set(VMIN, VMAX, 0, VMAX, 0, VMAX, VMIN));
    send_sample_set(make_set(0, 0, 10 * FIX_ONE, FIX_ONE / 4, 20 * FIX_ONE, FIX_ONE / 2,
                             FIX_ONE / 4));
    send_sample_set(make_set(0, 0, 10 * FIX_ONE, FIX_ONE / 4, 20 * FIX_ONE, FIX_ONE / 2,
                             FIX_ONE / 8));
    send_sample_set(make_set(0, 0, 10 * FIX_ONE, FIX_ONE / 4, 20 * FIX_ONE, FIX_ONE / 2,
                             FIX_ONE / 4 + 1));
    send_sample_set(make_set(0, 0, 10 * FIX_ONE, FIX_ONE / 4, 20 * FIX_ONE, FIX_ONE / 2,
                             2 * FIX_ONE));
    send_sample_set(make_set(5 * FIX_ONE, -FIX_ONE, -3 * FIX_ONE, -FIX_ONE / 2,
                             7 * FIX_ONE, 0, -3 * FIX_ONE / 4));
  endtask

  // Zero, short, boundary and negative segment lengths.
  task automatic test_span_limits();
    longint t;
    t = FIX_ONE / 4;
    send_sample_set(make_set(0, 0, 100, t, 200, t, t + 10));
    send_sample_set(make_set(0, 0, FIX_ONE, t, -FIX_ONE, t + 100, t + 50));
    send_sample_set(make_set(0, 0, 0, t, FIX_ONE, t + SPAN_MIN - 1, t + 500));
    send_sample_set(make_set(0, 0, 0, t, FIX_ONE, t + SPAN_MIN, t + 500));
    send_sample_set(make_set(0, 0, 0, t, FIX_ONE, t + SPAN_HALF, t + 1000));
    send_sample_set(make_set(0, 0, 0, t, FIX_ONE, t + SPAN_HALF + 1, t + 1000));
    send_sample_set(make_set(0, 0, 2 * FIX_ONE, FIX_ONE, 3 * FIX_ONE, FIX_ONE - 500,
                             FIX_ONE + 300));
    send_sample_set(make_set(0, 0, 2 * FIX_ONE, FIX_ONE, 3 * FIX_ONE, FIX_ONE - 40000,
                             FIX_ONE + 300));
    send_sample_set(make_set(-FIX_ONE, 0, FIX_ONE, 1, 0, 2, 1));
  endtask

  // Fraction saturation in both directions and saturation of the result.
  task automatic test_saturation();
    send_sample_set(make_set(0, VMIN, 0, VMIN, VMAX, VMIN + 1, VMAX));
    send_sample_set(make_set(0, VMIN, VMAX, VMIN + 10, VMIN, VMIN, VMAX));
    send_sample_set(make_set(0, VMIN, VMAX, VMIN + 10, VMIN, VMIN + 20, VMAX));
    send_sample_set(make_set(VMIN, VMIN, VMAX, VMAX, 0, VMAX, VMAX));
  endtask

  // A write to the unimplemented register index must change nothing.
  task automatic test_spare_register();
    wait_for_results();
    write_register(REG_SPARE, 32'hFFFF_FFFF);
    send_sample_set(make_set(0, 0, 3 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2, FIX_ONE / 8));
    send_sample_set(make_set(VMAX, 0, VMIN, FIX_ONE / 4, 0, FIX_ONE / 2, FIX_ONE / 8));
  endtask

  // Clamping to [min, max]; the held value stays unclamped.
  task automatic test_range_clamp();
    apply_config(-10 * FIX_ONE, 10 * FIX_ONE, 1'b0);
    send_sample_set(make_set(0, 0, 30 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2, FIX_ONE / 8));
    send_sample_set(make_set(0, 0, -30 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2,
                             FIX_ONE / 8));
    send_sample_set(make_set(50 * FIX_ONE, 0, 0, FIX_ONE / 4, 0, FIX_ONE / 2, 0));
    send_random_sets(150);
  endtask

  // Wrap-around in both directions over several ranges, degenerate ones too.
  task automatic test_cyclic_wrap();
    apply_config(0, 360 * FIX_ONE, 1'b1);
    send_sample_set(make_set(350 * FIX_ONE, 0, 10 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2,
                             FIX_ONE / 8));
    send_sample_set(make_set(350 * FIX_ONE, 0, 10 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2,
                             3 * FIX_ONE / 16));
    send_sample_set(make_set(10 * FIX_ONE, 0, 350 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2,
                             FIX_ONE / 8));
    send_sample_set(make_set(10 * FIX_ONE, 0, 350 * FIX_ONE, FIX_ONE / 4, 0, FIX_ONE / 2,
                             3 * FIX_ONE / 16));
    send_random_sets(100);
    apply_config(-180 * FIX_ONE, 180 * FIX_ONE, 1'b1);
    send_random_sets(100);
    apply_config(VMIN, VMAX, 1'b1);
    send_random_sets(80);
    apply_config(VMAX, VMIN, 1'b1);
    send_random_sets(80);
    apply_config(5 * FIX_ONE, 5 * FIX_ONE, 1'b1);
    send_random_sets(40);
  endtask

  // Long receiver hold-off while the sender keeps offering, then a gap-free stretch.
  task automatic test_output_stall();
    apply_config(-1000 * FIX_ONE, 1000 * FIX_ONE, 1'b0);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    holdoff_requests++;
    send_random_sets(150);
    wait_for_results();
    send_random_sets(100);
    wait_for_results();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // Random register settings plus the full range without wrapping.
  task automatic test_random_settings();
    repeat (3) begin
      apply_config(rand_word(), rand_word(), $urandom_range(0, 1));
      send_random_sets(100);
    end
    apply_config(VMIN, VMAX, 1'b0);
    send_random_sets(100);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cfg_min       = VMAX;
    cfg_max       = VMIN;
    cfg_cyclic    = 1'b0;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first directed cases run with the register values left by reset.
    test_hold_and_segments();
    test_span_limits();
    test_saturation();
    test_spare_register();
    test_range_clamp();
    test_cyclic_wrap();
    test_output_stall();
    test_random_settings();

    wait_for_results();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", VALUE_W'(pending_results.size()), '0);

    $display("Summary: %0d sample sets sent, %0d results checked, %0d register settings.",
             sets_sent, results_checked, settings_applied);
    $display("Covered hold, both segments, span limits, saturation, clamping and wrap-around.");
    if (mismatch_count == 0) begin
      $display("timed_sample_interpolator: match");
    end else begin
      $display("timed_sample_interpolator: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/tsi_pkg.sv
hdl/tsi_front.sv
hdl/tsi_div.sv
hdl/tsi_mul.sv
hdl/timed_sample_interpolator.sv
tb/timed_sample_interpolator_tb.sv
